// File: rtl/sil_pkg.sv
// Shared types and constants for the sorted insert list.
`default_nettype none

package sil_pkg;

  // Defaults for the top level parameters
  localparam int CAPACITY_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Width of the action, value and status fields of a beat
  localparam int ACTION_BITS = 2;
  localparam int PORT_BITS   = 32;
  localparam int STATUS_BITS = 2;
  // Widest value the store is built for; used for sign handling
  localparam int MAX_BITS    = 64;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_EMIT   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_ELEM  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_DROP  = 2'd2
  } status_t;

  // Command broadcast along the row of cells
  typedef struct packed {
    logic app;  // write at the tail
    logic ins;  // ordered insert, later cells move up by one
    logic pop;  // every cell takes its right neighbour's value, the last keeps its own
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sil_cell.sv
// One storage cell of the sorted insert list row.
`default_nettype none

module sil_cell #(
  parameter int VALUE_BITS = sil_pkg::VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire sil_pkg::cell_ctrl_t    ctrl,
  input  wire logic [VALUE_BITS-1:0]  v,
  input  wire logic [VALUE_BITS-1:0]  left_val,
  input  wire logic [VALUE_BITS-1:0]  right_val,
  input  wire logic                   found_in,
  input  wire logic                   valid,
  input  wire logic                   tail,
  output logic      [VALUE_BITS-1:0]  slot,
  output logic                        found_out
);
  import sil_pkg::*;

  logic                  ge;
  logic [VALUE_BITS-1:0] slot_next;

  // Insert point: first valid cell not less than v
  always_comb begin
    ge        = valid && !($signed(slot) < $signed(v));
    found_out = found_in | ge;
  end

  // Next value of the cell
  always_comb begin
    slot_next = slot;
    priority if (ctrl.pop) begin
      slot_next = right_val;
    end else if (ctrl.ins) begin
      if (!found_in && (ge || tail)) begin
        slot_next = v;
      end else if (found_in && (valid || tail)) begin
        slot_next = left_val;
      end
    end else if (ctrl.app && tail) begin
      slot_next = v;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

`default_nettype wire

// File: rtl/sorted_insert_list.sv
// Sorted insert list: a row of compare-and-shift cells holding an ordered store.
//
// Input channel (in_valid / in_stall, action and value): append puts the value
// at the tail, insert puts it ahead of the first stored value not less than it,
// emit streams the store out in order and clears it. Action code 3 is ignored.
// Output channel (out_valid / out_stall): value_out, status, last.
// Append and insert give no beat and run at one item per cycle while the input
// is not stalled; the cell row updates in the cycle after acceptance.
// Append or insert to a full store gives one drop beat (status 2), valid from
// the edge that accepts the item. Emit of an empty store gives one beat with
// status 1 and last set, with the same timing.
// Emit of N values gives N beats, one per cycle while out_stall is low; the
// accepting edge enters the emit state, which loads each beat into the output
// register and shifts the row down by one cell; the input is stalled meanwhile.
// Input is also stalled while a finished beat is held by out_stall.
// Reset empties the store at once; no clearing pass is needed.
`default_nettype none

module sorted_insert_list #(
  parameter int CAPACITY   = sil_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sil_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sil_pkg::ACTION_BITS-1:0]  action,
  input  wire logic [sil_pkg::PORT_BITS-1:0]    value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [sil_pkg::PORT_BITS-1:0]    value_out,
  output logic      [sil_pkg::STATUS_BITS-1:0]  status,
  output logic                                  last
);
  import sil_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [VALUE_BITS-1:0] v_int;
  logic [MAX_BITS-1:0]   v_wide;
  logic                  in_acc, out_free, full;
  cell_ctrl_t            ctrl;

  logic                  load;
  logic [PORT_BITS-1:0]  load_value;
  status_t               load_status;
  logic                  load_last;

  logic [VALUE_BITS-1:0] slot  [CAPACITY];
  logic                  found [CAPACITY+1];

  // Bring the port value to the store width, keeping its sign
  always_comb begin
    v_wide = {{(MAX_BITS-PORT_BITS){value[PORT_BITS-1]}}, value};
    v_int  = v_wide[VALUE_BITS-1:0];
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == CW'(CAPACITY));

  // Control: commands to the row, result loading, count and state
  always_comb begin
    state_next  = state;
    count_next  = count;
    ctrl        = '0;
    load        = 1'b0;
    load_value  = '0;
    load_status = STAT_ELEM;
    load_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_t'(action))
            ACT_APPEND, ACT_INSERT: begin
              if (full) begin
                load        = 1'b1;
                load_value  = PORT_BITS'({{(MAX_BITS-VALUE_BITS){1'b0}}, v_int});
                load_status = STAT_DROP;
              end else begin
                ctrl.app   = (action_t'(action) == ACT_APPEND);
                ctrl.ins   = (action_t'(action) == ACT_INSERT);
                count_next = count + CW'(1);
              end
            end
            ACT_EMIT: begin
              if (count == '0) begin
                load        = 1'b1;
                load_status = STAT_EMPTY;
                load_last   = 1'b1;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = PORT_BITS'({{(MAX_BITS-VALUE_BITS){1'b0}}, slot[0]});
          load_last  = (count == CW'(1));
          ctrl.pop   = 1'b1;
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      value_out <= load_value;
      status    <= load_status;
      last      <= load_last;
    end
  end

  // Row of cells; the insert point ripples from cell 0 upwards
  assign found[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = v_int;
    end else begin : g_mid
      assign left_val = slot[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_val = slot[g];
    end else begin : g_rest
      assign right_val = slot[g+1];
    end

    sil_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .v         (v_int),
      .left_val  (left_val),
      .right_val (right_val),
      .found_in  (found[g]),
      .valid     (CW'(g) < count),
      .tail      (CW'(g) == count),
      .slot      (slot[g]),
      .found_out (found[g+1])
    );
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> in_stall)
    else $error("input taken during emit");

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && action_t'(action) == ACT_EMIT && count != '0) |=> (state == ST_EMIT))
    else $error("emit of a filled store did not start streaming");

  a_drop_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_t'(status) == STAT_DROP) |-> !last)
    else $error("drop beat marked last");

  a_emit_empties: assert property (@(posedge clk) disable iff (rst)
    (load && load_last && state == ST_EMIT) |=> (count == '0))
    else $error("store not empty after last emitted beat");

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the sorted insert list, with a scoreboard and random idling.
`default_nettype none

module tb;
  import sil_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 10;
  localparam int LIMIT       = 500000;

  // One expected or observed output beat
  typedef struct {
    logic [PORT_BITS-1:0] value_out;
    status_t              status;
    logic                 last;
  } list_beat_t;

  // Ordered store predictor plus the queue of beats it still owes
  class list_scoreboard;
    logic signed [PORT_BITS-1:0] store[$];
    list_beat_t                  owed[$];
    int errors;
    int n_items;
    int n_ignored;
    int n_beats;
    int n_drops;
    int n_empty;

    function void owe(logic [PORT_BITS-1:0] v, status_t s, logic l);
      list_beat_t b;
      b.value_out = v;
      b.status    = s;
      b.last      = l;
      owed.push_back(b);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Accepted input beat: update the store and note the beats it causes
    function void note_input(action_t act, logic signed [PORT_BITS-1:0] v);
      int pos;
      n_items++;
      case (act)
        ACT_APPEND, ACT_INSERT: begin
          if (store.size() >= CAP) begin
            owe(v, STAT_DROP, 1'b0);
            n_drops++;
          end else if (act == ACT_APPEND) begin
            store.push_back(v);
          end else begin
            // lands ahead of the first entry not less than it
            pos = 0;
            while (pos < store.size() && store[pos] < v) pos++;
            store.insert(pos, v);
          end
        end
        ACT_EMIT: begin
          if (store.size() == 0) begin
            owe('0, STAT_EMPTY, 1'b1);
            n_empty++;
          end else begin
            foreach (store[i]) owe(store[i], STAT_ELEM, i == store.size() - 1);
            store.delete();
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    // Accepted output beat against the oldest owed beat
    task check_result(logic [PORT_BITS-1:0] vo, logic [STATUS_BITS-1:0] st, logic l);
      list_beat_t b;
      n_beats++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected beat value_out=%h status=%0d last=%b", vo, st, l));
      end else begin
        b = owed.pop_front();
        if (vo !== b.value_out)
          report($sformatf("value_out %h, wanted %h", vo, b.value_out));
        if (st !== b.status)
          report($sformatf("status %0d, wanted %0d", st, b.status));
        if (l !== b.last)
          report($sformatf("last %b, wanted %b", l, b.last));
      end
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  action_t                act       = ACT_APPEND;
  logic [PORT_BITS-1:0]   value     = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PORT_BITS-1:0]   value_out;
  logic [STATUS_BITS-1:0] status;
  logic                   last;

  int  send_idle  = 0;
  int  recv_stall = 0;
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;
  int  items_sent = 0;
  int  cycles     = 0;

  list_scoreboard sb = new();

  sorted_insert_list uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (act),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .status    (status),
    .last      (last)
  );

  always #5 clk = ~clk;

  // Both channel monitors sample at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(act, value);
    if (!rst && out_valid && !out_stall) sb.check_result(value_out, status, last);
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one beat; entered and left just after a falling edge
  task send(action_t a, logic [PORT_BITS-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    act      <= a;
    value    <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (a != ACT_NONE) items_sent++;
  endtask

  function logic [PORT_BITS-1:0] rand_value();
    case ($urandom_range(3))
      0:       return PORT_BITS'($urandom_range(0, 16)) - PORT_BITS'(8);
      1: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Base list built by appends, then ordered inserts (with occasional swaps and unused codes), then an emit
  task run_seq(bit overflow);
    int n;
    int base;
    action_t a;
    n    = overflow ? CAP + $urandom_range(1, 3) : $urandom_range(1, 8);
    base = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      a = (i < base) ? ACT_APPEND : ACT_INSERT;
      if ($urandom_range(9) == 0) a = action_t'($urandom_range(0, 1));
      if ($urandom_range(19) == 0) send(ACT_NONE, $urandom);
      send(a, rand_value());
    end
    send(ACT_EMIT, $urandom);
    // occasional emit of the now empty store
    if ($urandom_range(7) == 0) send(ACT_EMIT, $urandom);
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty emit, unused code, extremes, equal values, unsorted base
    send(ACT_EMIT,   32'hffff_ffff);
    send(ACT_NONE,   32'h1234_5678);
    send(ACT_EMIT,   32'h0000_0000);
    send(ACT_APPEND, 32'h0000_0000);
    send(ACT_APPEND, 32'h7fff_ffff);
    send(ACT_APPEND, 32'h8000_0000);
    send(ACT_INSERT, 32'hffff_ffff);
    send(ACT_INSERT, 32'h8000_0000);
    send(ACT_INSERT, 32'h7fff_ffff);
    send(ACT_INSERT, 32'h0000_0005);
    send(ACT_EMIT,   32'h5555_5555);
    send(ACT_INSERT, 32'h0000_0005);
    send(ACT_INSERT, 32'h0000_0003);
    send(ACT_INSERT, 32'h0000_0003);
    send(ACT_INSERT, 32'h0000_0007);
    send(ACT_APPEND, 32'h0000_0001);
    send(ACT_NONE,   32'haaaa_aaaa);
    send(ACT_INSERT, 32'h0000_0002);
    send(ACT_EMIT,   32'haaaa_aaaa);
    send(ACT_EMIT,   32'h0000_0000);

    // Idling phases: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 85; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      target = items_sent + 20;
      if (ph == 0) begin
        // long receiver hold-off while the store fills and overflows
        hold_req = 1'b1;
        run_seq(1'b1);
      end
      while (items_sent < target) run_seq($urandom_range(9) == 0);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d accepted beats (%0d unused code) and %0d result beats,",
             sb.n_items, sb.n_ignored, sb.n_beats);
    $display("including %0d full-store drops and %0d empty emits, over four idling mixes.",
             sb.n_drops, sb.n_empty);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
